>>> design/dtr_pkg.sv
`default_nettype none

package dtr_pkg;

  localparam int NUM_BUFFERS = 2;
  localparam int LIST_SLOTS  = 32;

  localparam int BUF_W  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int SLOT_W = $clog2(LIST_SLOTS);
  localparam int ADDR_W = BUF_W + SLOT_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam int X_W   = 12;
  localparam int Y_W   = 12;
  localparam int DIM_W = 13;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DIM_W;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_MARK  = 2'd0,
    CMD_SWEEP = 2'd1,
    CMD_SWAP  = 2'd2
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } rect_t;

  typedef struct packed {
    rect_t rect;
    logic  last;
    logic  empty_res;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t data;
  } q_ctl_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

`default_nettype wire

>>> design/dtr_in_if.sv
`default_nettype none

interface dtr_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [dtr_pkg::X_W-1:0]       rect_x;
  logic [dtr_pkg::Y_W-1:0]       rect_y;
  logic [dtr_pkg::DIM_W-1:0]     rect_w;
  logic [dtr_pkg::DIM_W-1:0]     rect_h;

  modport source (output valid, command, rect_x, rect_y, rect_w, rect_h, input ready);
  modport sink (input valid, command, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

`default_nettype wire

>>> design/dtr_out_if.sv
`default_nettype none

interface dtr_out_if;
  logic                          valid;
  logic                          ready;
  logic [dtr_pkg::X_W-1:0]       out_x;
  logic [dtr_pkg::Y_W-1:0]       out_y;
  logic [dtr_pkg::DIM_W-1:0]     out_w;
  logic [dtr_pkg::DIM_W-1:0]     out_h;
  logic                          last;
  logic                          empty_res;

  modport source (output valid, out_x, out_y, out_w, out_h, last, empty_res, input ready);
  modport sink (input valid, out_x, out_y, out_w, out_h, last, empty_res, output ready);
endinterface

`default_nettype wire

>>> design/dirty_rect_tracker.sv
`default_nettype none

// Channel   Role    Transaction
// in_ch     sink    one command: mark, sweep or swap, with the rectangle for a mark
// out_ch    source  one rectangle to redraw, or one empty flag for an empty sweep
// config    write   write_enable, reg_index, write_data; taken at every enabled edge
//
// A swap only steps the buffer select. After acceptance a mark writes each buffer's list in
// turn, one write per buffer through the single write port of the rectangle memory.
// A sweep reads its list in order, and the read in flight counts against the two-entry
// output queue, so a read is issued only while the queue has room for it; in_ch is held off
// while the sweep reads, and its last results reach out_ch after in_ch is ready again.
// Reset clears the buffer select, the list counts and the queue; the memory is not cleared.
// A stall on out_ch pauses a sweep, empty or not, and in_ch stays not ready until the sweep
// has issued its last read or pushed its empty flag; a mark or a swap never waits on out_ch.

module dirty_rect_tracker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  dtr_in_if.sink                                in_ch,
  dtr_out_if.source                             out_ch,
  input  wire logic                             write_enable,
  input  wire logic [dtr_pkg::CFG_IDX_W-1:0]    reg_index,
  input  wire logic [dtr_pkg::CFG_DATA_W-1:0]   write_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MARK  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_EMPTY = 4'b1000
  } state_t;

  state_t                          state;
  logic [dtr_pkg::BUF_W-1:0]       sel;
  logic [dtr_pkg::BUF_W-1:0]       mark_buf;
  logic [dtr_pkg::SLOT_W-1:0]      counts [dtr_pkg::NUM_BUFFERS];
  dtr_pkg::rect_t                  mark_rect;
  logic [dtr_pkg::SLOT_W-1:0]      sweep_idx;
  logic [dtr_pkg::SLOT_W-1:0]      sweep_n;
  logic                            rd_pending;
  logic                            rd_last;
  logic [dtr_pkg::DIM_W-1:0]       screen_width;
  logic [dtr_pkg::DIM_W-1:0]       screen_height;

  logic                            in_accept;
  logic [dtr_pkg::SLOT_W-1:0]      mark_cnt;
  logic                            mark_wrap;
  logic                            mark_done;
  dtr_pkg::rect_t                  full_rect;
  dtr_pkg::rect_t                  mem_wdata;
  logic                            mem_we;
  logic [dtr_pkg::ADDR_W-1:0]      mem_waddr;
  logic                            rd_issue;
  logic [dtr_pkg::ADDR_W-1:0]      mem_raddr;
  dtr_pkg::rect_t                  mem_rdata;
  logic                            sweep_end;
  logic [dtr_pkg::QCNT_W:0]        occupancy;
  logic                            room;
  logic                            empty_push;
  dtr_pkg::q_ctl_t                 q_ctl;
  dtr_pkg::q_stat_t                q_stat;

  assign in_accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state == S_IDLE);

  assign full_rect.x = '0;
  assign full_rect.y = '0;
  assign full_rect.w = screen_width;
  assign full_rect.h = screen_height;

  // A full list collapses to one full-screen rectangle, which then replaces the
  // marked rectangle for the buffers that follow.
  assign mark_cnt  = counts[mark_buf];
  assign mark_wrap = (mark_cnt == dtr_pkg::SLOT_W'(dtr_pkg::LIST_SLOTS - 1));
  assign mark_done = (mark_buf == dtr_pkg::BUF_W'(dtr_pkg::NUM_BUFFERS - 1));
  assign mem_we    = (state == S_MARK);
  assign mem_wdata = mark_wrap ? full_rect : mark_rect;
  assign mem_waddr = {mark_buf, (mark_wrap ? dtr_pkg::SLOT_W'(0) : mark_cnt)};

  // Results in the queue plus the read in flight must fit the queue.
  assign occupancy  = {1'b0, q_stat.count} + (dtr_pkg::QCNT_W + 1)'(rd_pending);
  assign room       = (occupancy < (dtr_pkg::QCNT_W + 1)'(dtr_pkg::Q_DEPTH));
  assign rd_issue   = (state == S_SWEEP) && room;
  assign mem_raddr  = {sel, sweep_idx};
  assign sweep_end  = (sweep_idx == (sweep_n - dtr_pkg::SLOT_W'(1)));
  assign empty_push = (state == S_EMPTY) && room && !rd_pending;

  always_comb begin
    q_ctl.push = rd_pending || empty_push;
    if (rd_pending) begin
      q_ctl.data.rect      = mem_rdata;
      q_ctl.data.last      = rd_last;
      q_ctl.data.empty_res = 1'b0;
    end else begin
      q_ctl.data.rect      = '0;
      q_ctl.data.last      = 1'b1;
      q_ctl.data.empty_res = 1'b1;
    end
  end

  dtr_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_issue),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dtr_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .ctl    (q_ctl),
    .stat   (q_stat),
    .out_ch (out_ch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= dtr_pkg::DIM_W'(640);
      screen_height <= dtr_pkg::DIM_W'(480);
    end else if (write_enable) begin
      case (reg_index)
        dtr_pkg::REG_SCREEN_WIDTH:  screen_width  <= write_data;
        dtr_pkg::REG_SCREEN_HEIGHT: screen_height <= write_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (in_ch.command == dtr_pkg::CMD_MARK)) begin
      mark_rect.x <= in_ch.rect_x;
      mark_rect.y <= in_ch.rect_y;
      mark_rect.w <= in_ch.rect_w;
      mark_rect.h <= in_ch.rect_h;
    end else if (mem_we && mark_wrap) begin
      mark_rect <= full_rect;
    end
    if (rd_issue) begin
      rd_last <= sweep_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sel        <= '0;
      mark_buf   <= '0;
      sweep_idx  <= '0;
      sweep_n    <= '0;
      rd_pending <= 1'b0;
      for (int b = 0; b < dtr_pkg::NUM_BUFFERS; b++) begin
        counts[b] <= '0;
      end
    end else begin
      rd_pending <= rd_issue;
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            case (in_ch.command)
              dtr_pkg::CMD_MARK: begin
                mark_buf <= '0;
                state    <= S_MARK;
              end
              dtr_pkg::CMD_SWEEP: begin
                sweep_idx <= '0;
                sweep_n   <= counts[sel];
                state     <= (counts[sel] == '0) ? S_EMPTY : S_SWEEP;
              end
              dtr_pkg::CMD_SWAP: begin
                sel <= (sel == dtr_pkg::BUF_W'(dtr_pkg::NUM_BUFFERS - 1)) ? '0 : sel + 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_MARK: begin
          counts[mark_buf] <= mark_wrap ? dtr_pkg::SLOT_W'(1) : mark_cnt + 1'b1;
          mark_buf         <= mark_buf + 1'b1;
          if (mark_done) begin
            state <= S_IDLE;
          end
        end
        S_SWEEP: begin
          if (rd_issue) begin
            sweep_idx <= sweep_idx + 1'b1;
            if (sweep_end) begin
              counts[sel] <= '0;
              state       <= S_IDLE;
            end
          end
        end
        S_EMPTY: begin
          if (empty_push) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/dtr_ram.sv
`default_nettype none

module dtr_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [dtr_pkg::ADDR_W-1:0]  waddr,
  input  wire dtr_pkg::rect_t              wdata,
  input  wire logic                        re,
  input  wire logic [dtr_pkg::ADDR_W-1:0]  raddr,
  output dtr_pkg::rect_t                   rdata
);

  dtr_pkg::rect_t mem [dtr_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/dtr_outq.sv
`default_nettype none

module dtr_outq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dtr_pkg::q_ctl_t  ctl,
  output dtr_pkg::q_stat_t      stat,
  dtr_out_if.source             out_ch
);

  dtr_pkg::result_t             entries [dtr_pkg::Q_DEPTH];
  logic [dtr_pkg::QPTR_W-1:0]   wr_ptr;
  logic [dtr_pkg::QPTR_W-1:0]   rd_ptr;
  logic [dtr_pkg::QCNT_W-1:0]   count;
  logic                         pop;
  dtr_pkg::result_t             head;

  assign pop  = out_ch.valid && out_ch.ready;
  assign head = entries[rd_ptr];

  assign out_ch.valid     = (count != '0);
  assign out_ch.out_x     = head.rect.x;
  assign out_ch.out_y     = head.rect.y;
  assign out_ch.out_w     = head.rect.w;
  assign out_ch.out_h     = head.rect.h;
  assign out_ch.last      = head.last;
  assign out_ch.empty_res = head.empty_res;
  assign stat.count       = count;

  // The producer only pushes when it has counted a free slot.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entries[wr_ptr] <= ctl.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr <= (wr_ptr == dtr_pkg::QPTR_W'(dtr_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == dtr_pkg::QPTR_W'(dtr_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({ctl.push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire
